[sv/cia_pkg.sv]
`default_nettype none
package cia_pkg;

	localparam int RES_BITS = 33;
	localparam int OPERAND_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Everything that rides alongside the divider lanes.
	typedef struct packed {
		logic [RES_BITS-1:0] re;
		logic [RES_BITS-1:0] im;
		logic                dz;
		logic                is_div;
		logic                neg_re;
		logic                neg_im;
	} side_t;

endpackage
`default_nettype wire

[sv/cia_front.sv]
`default_nettype none
module cia_front #(
	parameter int W = cia_pkg::OPERAND_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire cia_pkg::op_t   op,
	input  wire signed [W-1:0]  ar,
	input  wire signed [W-1:0]  ai,
	input  wire signed [W-1:0]  br,
	input  wire signed [W-1:0]  bi,
	output logic                out_valid,
	input  wire                 out_ready,
	output cia_pkg::side_t      side,
	output logic [2*W-1:0]      num_re,
	output logic [2*W-1:0]      num_im,
	output logic [2*W-1:0]      den
);
	import cia_pkg::*;

	localparam int PW = 2 * W;

	logic                 valid_s1;
	logic                 ready_s1;
	op_t                  op_s1;
	logic                 dz_s1;
	logic signed [W:0]    as_re_s1;
	logic signed [W:0]    as_im_s1;
	logic signed [PW-1:0] p_rr_s1;
	logic signed [PW-1:0] p_ii_s1;
	logic signed [PW-1:0] p_ri_s1;
	logic signed [PW-1:0] p_ir_s1;
	logic signed [PW-1:0] sq_r_s1;
	logic signed [PW-1:0] sq_i_s1;

	logic                 valid_s2;
	side_t                side_s2;
	logic [PW-1:0]        num_re_s2;
	logic [PW-1:0]        num_im_s2;
	logic [PW-1:0]        den_s2;

	logic signed [PW:0]   mul_re;
	logic signed [PW:0]   mul_im;
	logic signed [PW:0]   dnum_re;
	logic signed [PW:0]   dnum_im;
	logic signed [PW:0]   dmag_re;
	logic signed [PW:0]   dmag_im;
	side_t                side_d;

	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			dz_s1 <= (br == '0) && (bi == '0);
			if (op == OP_ADD) begin
				as_re_s1 <= (W+1)'(ar) + (W+1)'(br);
				as_im_s1 <= (W+1)'(ai) + (W+1)'(bi);
			end else begin
				as_re_s1 <= (W+1)'(ar) - (W+1)'(br);
				as_im_s1 <= (W+1)'(ai) - (W+1)'(bi);
			end
			p_rr_s1 <= ar * br;
			p_ii_s1 <= ai * bi;
			p_ri_s1 <= ar * bi;
			p_ir_s1 <= ai * br;
			sq_r_s1 <= br * br;
			sq_i_s1 <= bi * bi;
		end
	end

	assign mul_re  = (PW+1)'(p_rr_s1) - (PW+1)'(p_ii_s1);
	assign mul_im  = (PW+1)'(p_ri_s1) + (PW+1)'(p_ir_s1);
	assign dnum_re = (PW+1)'(p_rr_s1) + (PW+1)'(p_ii_s1);
	assign dnum_im = (PW+1)'(p_ir_s1) - (PW+1)'(p_ri_s1);
	assign dmag_re = dnum_re[PW] ? -dnum_re : dnum_re;
	assign dmag_im = dnum_im[PW] ? -dnum_im : dnum_im;

	always_comb begin
		side_d        = '0;
		side_d.neg_re = dnum_re[PW];
		side_d.neg_im = dnum_im[PW];
		case (op_s1)
			OP_ADD, OP_SUB: begin
				side_d.re = RES_BITS'(as_re_s1);
				side_d.im = RES_BITS'(as_im_s1);
			end
			OP_MUL: begin
				side_d.re = RES_BITS'(mul_re);
				side_d.im = RES_BITS'(mul_im);
			end
			OP_DIV: begin
				side_d.dz     = dz_s1;
				side_d.is_div = !dz_s1;
			end
			default: begin
				side_d.re = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			side_s2   <= side_d;
			num_re_s2 <= dmag_re[PW-1:0];
			num_im_s2 <= dmag_im[PW-1:0];
			den_s2    <= PW'($unsigned(sq_r_s1)) + PW'($unsigned(sq_i_s1));
		end
	end

	assign out_valid = valid_s2;
	assign side      = side_s2;
	assign num_re    = num_re_s2;
	assign num_im    = num_im_s2;
	assign den       = den_s2;

endmodule
`default_nettype wire

[sv/cia_div_cell.sv]
`default_nettype none
module cia_div_cell #(
	parameter int NW = 2 * cia_pkg::OPERAND_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire cia_pkg::side_t  in_side,
	input  wire [NW-1:0]         in_den,
	input  wire [NW-1:0]         in_rem_re,
	input  wire [NW-1:0]         in_rem_im,
	input  wire [NW-1:0]         in_num_re,
	input  wire [NW-1:0]         in_num_im,
	output logic                 out_valid,
	input  wire                  out_ready,
	output cia_pkg::side_t       out_side,
	output logic [NW-1:0]        out_den,
	output logic [NW-1:0]        out_rem_re,
	output logic [NW-1:0]        out_rem_im,
	output logic [NW-1:0]        out_num_re,
	output logic [NW-1:0]        out_num_im
);
	import cia_pkg::*;

	logic            valid_q;
	side_t           side_q;
	logic [NW-1:0]   den_q;
	logic [NW-1:0]   rem_re_q;
	logic [NW-1:0]   rem_im_q;
	logic [NW-1:0]   num_re_q;
	logic [NW-1:0]   num_im_q;

	logic [NW:0]     sh_re;
	logic [NW:0]     sh_im;
	logic [NW:0]     diff_re;
	logic [NW:0]     diff_im;

	// One restoring step per lane: the numerator shifts into the remainder
	// and the quotient bit fills the vacated low end.
	assign sh_re   = {in_rem_re, in_num_re[NW-1]};
	assign sh_im   = {in_rem_im, in_num_im[NW-1]};
	assign diff_re = sh_re - {1'b0, in_den};
	assign diff_im = sh_im - {1'b0, in_den};

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_q   <= in_side;
			den_q    <= in_den;
			rem_re_q <= diff_re[NW] ? sh_re[NW-1:0] : diff_re[NW-1:0];
			rem_im_q <= diff_im[NW] ? sh_im[NW-1:0] : diff_im[NW-1:0];
			num_re_q <= {in_num_re[NW-2:0], !diff_re[NW]};
			num_im_q <= {in_num_im[NW-2:0], !diff_im[NW]};
		end
	end

	assign out_valid  = valid_q;
	assign out_side   = side_q;
	assign out_den    = den_q;
	assign out_rem_re = rem_re_q;
	assign out_rem_im = rem_im_q;
	assign out_num_re = num_re_q;
	assign out_num_im = num_im_q;

endmodule
`default_nettype wire

[sv/complex_integer_alu.sv]
`default_nettype none
// Channel   Direction  tdata (low bit up)                       tuser
// s_axis    in         a_real, a_imag, b_real, b_imag, pad       req_type
// m_axis    out        res_real, res_imag, pad                   div_by_zero
//
// The pipeline has two front stages of multipliers and adders, one divider
// cell per quotient bit, and an output register. A new word is accepted
// every cycle while the output is not stalled.
// Each stage holds its word while the next is full, so a stalled output
// fills the chain before s_axis_tready drops. Reset clears only valid bits.
module complex_integer_alu #(
	parameter int OPERAND_BITS = cia_pkg::OPERAND_BITS_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_axis_tvalid,
	output logic s_axis_tready,
	// a_real, a_imag, b_real, b_imag, zero padding
	input  wire  [((4*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
	// req_type
	input  wire  [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  wire  m_axis_tready,
	// res_real, res_imag, zero padding
	output logic [((2*cia_pkg::RES_BITS+7)/8)*8-1:0] m_axis_tdata,
	// div_by_zero
	output logic m_axis_tuser
);
	import cia_pkg::*;

	localparam int W    = OPERAND_BITS;
	localparam int NW   = 2 * W;
	localparam int OUTW = ((2 * RES_BITS + 7) / 8) * 8;

	logic           v   [NW+1];
	logic           r   [NW+1];
	side_t          sd  [NW+1];
	logic [NW-1:0]  dn  [NW+1];
	logic [NW-1:0]  rre [NW+1];
	logic [NW-1:0]  rim [NW+1];
	logic [NW-1:0]  nre [NW+1];
	logic [NW-1:0]  nim [NW+1];

	logic                 out_valid_q;
	logic [RES_BITS-1:0]  res_re_q;
	logic [RES_BITS-1:0]  res_im_q;
	logic                 dz_q;
	logic                 last_ready;
	logic signed [NW:0]   q_re;
	logic signed [NW:0]   q_im;
	logic [RES_BITS-1:0]  fin_re;
	logic [RES_BITS-1:0]  fin_im;

	cia_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (op_t'(s_axis_tuser)),
		.ar        (s_axis_tdata[W-1:0]),
		.ai        (s_axis_tdata[2*W-1:W]),
		.br        (s_axis_tdata[3*W-1:2*W]),
		.bi        (s_axis_tdata[4*W-1:3*W]),
		.out_valid (v[0]),
		.out_ready (r[0]),
		.side      (sd[0]),
		.num_re    (nre[0]),
		.num_im    (nim[0]),
		.den       (dn[0])
	);

	assign rre[0] = '0;
	assign rim[0] = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		cia_div_cell #(.NW(NW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (v[i]),
			.in_ready   (r[i]),
			.in_side    (sd[i]),
			.in_den     (dn[i]),
			.in_rem_re  (rre[i]),
			.in_rem_im  (rim[i]),
			.in_num_re  (nre[i]),
			.in_num_im  (nim[i]),
			.out_valid  (v[i+1]),
			.out_ready  (r[i+1]),
			.out_side   (sd[i+1]),
			.out_den    (dn[i+1]),
			.out_rem_re (rre[i+1]),
			.out_rem_im (rim[i+1]),
			.out_num_re (nre[i+1]),
			.out_num_im (nim[i+1])
		);
	end

	assign last_ready = !out_valid_q || m_axis_tready;
	assign r[NW]      = last_ready;

	assign q_re   = sd[NW].neg_re ? -$signed({1'b0, nre[NW]}) : $signed({1'b0, nre[NW]});
	assign q_im   = sd[NW].neg_im ? -$signed({1'b0, nim[NW]}) : $signed({1'b0, nim[NW]});
	assign fin_re = sd[NW].is_div ? RES_BITS'(q_re) : sd[NW].re;
	assign fin_im = sd[NW].is_div ? RES_BITS'(q_im) : sd[NW].im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (last_ready && v[NW]) begin
			res_re_q <= fin_re;
			res_im_q <= fin_im;
			dz_q     <= sd[NW].dz;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUTW'({res_im_q, res_re_q});
	assign m_axis_tuser  = dz_q;

endmodule
`default_nettype wire
